@@ rtl/core/hlt_pkg.sv @@
// Shared types, constants and helpers of the hierarchical lock table.
// Used by hlt_parent_ram and hierarchical_lock_table_core; depends on nothing.
package hlt_pkg;

   localparam int NODES  = 64;
   localparam int NODE_W = $clog2(NODES);
   localparam int CNT_W  = NODE_W + 1;
   localparam int PAR_W  = NODE_W + 1;
   localparam int USER_W = 16;
   localparam int REQ_W  = 32;
   localparam int RSP_W  = 8;

   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_LOCK    = 2'd1,
      CMD_UNLOCK  = 2'd2,
      CMD_UPGRADE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UNLK,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_SWEEP,
      ST_APPLY,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic              hit;
      logic [NODE_W-1:0] idx;
   } par_type;

   function automatic logic [CNT_W-1:0] active_count(input logic [CNT_W-1:0] cnt);
      logic [CNT_W-1:0] r;
      r = cnt;
      if (cnt == '0) begin
         r = CNT_W'(1);
      end else if (cnt > CNT_W'(NODES)) begin
         r = CNT_W'(NODES);
      end
      return r;
   endfunction

endpackage

@@ rtl/core/hlt_parent_ram.sv @@
// Parent table memory with one write and one registered read port,
// decoding the read entry into a parent lookup. Depends on hlt_pkg.
module hlt_parent_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [hlt_pkg::NODE_W-1:0] wr_addr,
   input  logic [hlt_pkg::PAR_W-1:0]  wr_data,
   input  logic [hlt_pkg::NODE_W-1:0] rd_addr,
   input  logic [hlt_pkg::CNT_W-1:0]  active,
   output hlt_pkg::par_type           rd_par
);
   import hlt_pkg::*;

   logic [PAR_W-1:0] mem [NODES];
   logic [PAR_W-1:0] raw_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      raw_ff <= mem[rd_addr];
   end

   assign rd_par.hit = !raw_ff[PAR_W-1] && ({1'b0, raw_ff[NODE_W-1:0]} < active);
   assign rd_par.idx = raw_ff[NODE_W-1:0];

endmodule

@@ rtl/core/hierarchical_lock_table_core.sv @@
// Hierarchical lock table top level: stream channels, sequencer, lock state
// and owner memory. Depends on hlt_pkg and hlt_parent_ram.
//
// Usage: one request item on req_* gives exactly one response item on rsp_*.
// A request carries command, node, user and parent; the response carries the
// success flag. csr_wen/csr_wdata set the number of nodes in use; the user
// must write them only while idle, as the block itself does not enforce it.
// Load and lock go from idle straight to the final state; unlock passes
// through ST_UNLK first. Upgrade walks the ancestors (up to n steps), then
// sweeps the parent table for descendants, one parent read per cycle,
// repeating until a pass marks nothing new (at most n passes), then applies
// the result before the final state.
// The parent memory read port sets the rate. req_tready is high only while
// the sequencer is idle. The response sits in an output register, so a new
// request is taken while it waits; a stalled receiver holds the sequencer in
// its final state until the output register frees up.
// Reset unlocks every node and sets the node count to 64; the parent table
// keeps its contents and must be loaded before use.
module hierarchical_lock_table_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [1:0] command, [7:2] node, [23:8] user, [30:24] parent_node, [31] zero
   input  logic [hlt_pkg::REQ_W-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [0] success, [7:1] zero
   output logic [hlt_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                     csr_wen,
   input  logic [hlt_pkg::CNT_W-1:0] csr_wdata
);
   import hlt_pkg::*;

   localparam logic [NODES-1:0] ONE_HOT0 = {{(NODES-1){1'b0}}, 1'b1};

   state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  n_act;
   cmd_type           cmd_ff, cmd_in;
   logic [NODE_W-1:0] nd_ff, nd_in;
   logic [USER_W-1:0] usr_ff, usr_in;
   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [CNT_W-1:0]  step_ff, step_in;
   logic [NODES-1:0]  lk_ff, lk_in;
   logic [NODES-1:0]  mark_ff, mark_in;
   logic [CNT_W-1:0]  sidx_ff, sidx_in;
   logic              pend_ff, pend_in;
   logic [NODE_W-1:0] pidx_ff, pidx_in;
   logic              chg_ff, chg_in;
   logic              ok_ff, ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;

   logic [USER_W-1:0] own_mem [NODES];
   logic [USER_W-1:0] own_rd_ff;
   logic              own_we;
   logic [NODE_W-1:0] own_wa;
   logic [USER_W-1:0] own_wd;

   cmd_type           rq_cmd;
   logic [NODE_W-1:0] rq_node;
   logic [USER_W-1:0] rq_user;
   logic [PAR_W-1:0]  rq_par;

   logic              acc;
   logic              in_range;
   logic              slot_free;
   logic              walk_last;
   logic              sweep_end;
   logic [NODES-1:0]  nd_hot;
   logic [NODES-1:0]  desc;
   logic              found;
   logic [USER_W-1:0] own_cur;
   logic [NODE_W-1:0] par_addr;
   par_type           rd_par;

   assign rq_cmd  = cmd_type'(req_tdata[1:0]);
   assign rq_node = req_tdata[7:2];
   assign rq_user = req_tdata[23:8];
   assign rq_par  = req_tdata[30:24];

   assign n_act      = active_count(cnt_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign acc        = req_tvalid && req_tready;
   assign in_range   = ({1'b0, rq_node} < n_act);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign walk_last  = ((step_ff + CNT_W'(1)) == n_act);
   assign sweep_end  = (sidx_ff == n_act) && !pend_ff;
   assign nd_hot     = ONE_HOT0 << nd_ff;
   assign desc       = mark_ff & lk_ff & ~nd_hot & ~ONE_HOT0;
   assign found      = |desc;
   assign own_cur    = lk_ff[nd_ff] ? own_rd_ff : '0;
   assign par_addr   = (state_ff == ST_SWEEP) ? sidx_ff[NODE_W-1:0] : cur_ff;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-1){1'b0}}, rsp_ok_ff};

   hlt_parent_ram u_parent (
      .clock   (clock),
      .wr_en   (acc && (rq_cmd == CMD_LOAD)),
      .wr_addr (rq_node),
      .wr_data (rq_par),
      .rd_addr (par_addr),
      .active  (n_act),
      .rd_par  (rd_par)
   );

   always_ff @(posedge clock) begin
      if (own_we) begin
         own_mem[own_wa] <= own_wd;
      end
      own_rd_ff <= own_mem[rq_node];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               case (rq_cmd)
                  CMD_UNLOCK:  state_in = in_range ? ST_UNLK : ST_FIN;
                  CMD_UPGRADE: state_in = in_range ? ST_WALK_RD : ST_FIN;
                  default:     state_in = ST_FIN;
               endcase
            end
         end
         ST_UNLK:    state_in = ST_FIN;
         ST_WALK_RD: state_in = ST_WALK_CHK;
         ST_WALK_CHK: begin
            if (lk_ff[cur_ff]) begin
               state_in = ST_FIN;
            end else if (!rd_par.hit || walk_last) begin
               state_in = ST_SWEEP;
            end else begin
               state_in = ST_WALK_RD;
            end
         end
         ST_SWEEP: begin
            if (sweep_end && !chg_ff) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: state_in = ST_FIN;
         ST_FIN: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_in       = cmd_ff;
      nd_in        = nd_ff;
      usr_in       = usr_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      lk_in        = lk_ff;
      mark_in      = mark_ff;
      sidx_in      = sidx_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      chg_in       = chg_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      own_we       = 1'b0;
      own_wa       = nd_ff;
      own_wd       = usr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               cmd_in  = rq_cmd;
               nd_in   = rq_node;
               usr_in  = rq_user;
               cur_in  = rq_node;
               step_in = '0;
               ok_in   = 1'b0;
               case (rq_cmd)
                  CMD_LOAD: ok_in = 1'b1;
                  CMD_LOCK: begin
                     if (in_range && !lk_ff[rq_node]) begin
                        own_we         = 1'b1;
                        own_wa         = rq_node;
                        own_wd         = rq_user;
                        lk_in[rq_node] = (rq_user != '0);
                        ok_in          = 1'b1;
                     end
                  end
                  default: ok_in = 1'b0;
               endcase
            end
         end
         ST_UNLK: begin
            if (own_cur == usr_ff) begin
               lk_in[nd_ff] = 1'b0;
               ok_in        = 1'b1;
            end
         end
         ST_WALK_CHK: begin
            cur_in  = rd_par.idx;
            step_in = step_ff + CNT_W'(1);
            mark_in = nd_hot;
            sidx_in = '0;
            pend_in = 1'b0;
            chg_in  = 1'b0;
         end
         ST_SWEEP: begin
            if (sidx_ff < n_act) begin
               pend_in = 1'b1;
               pidx_in = sidx_ff[NODE_W-1:0];
               sidx_in = sidx_ff + CNT_W'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && (pidx_ff != nd_ff) && rd_par.hit && mark_ff[rd_par.idx]
                && !mark_ff[pidx_ff]) begin
               mark_in[pidx_ff] = 1'b1;
               chg_in           = 1'b1;
            end
            if (sweep_end) begin
               sidx_in = '0;
               chg_in  = 1'b0;
            end
         end
         ST_APPLY: begin
            if (found) begin
               lk_in        = lk_ff & ~desc;
               lk_in[nd_ff] = (usr_ff != '0);
               own_we       = 1'b1;
               ok_in        = 1'b1;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
            end
         end
         default: ok_in = ok_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= CNT_W'(NODES);
         lk_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         chg_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lk_ff        <= lk_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         chg_ff       <= chg_in;
         if (csr_wen) begin
            cnt_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      nd_ff     <= nd_in;
      usr_ff    <= usr_in;
      cur_ff    <= cur_in;
      step_ff   <= step_in;
      mark_ff   <= mark_in;
      sidx_ff   <= sidx_in;
      pidx_ff   <= pidx_in;
      ok_ff     <= ok_in;
      rsp_ok_ff <= rsp_ok_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && cmd_ff == CMD_LOCK && ok_ff) |-> (lk_ff[nd_ff] == (usr_ff != '0)))
      else $error("lock success did not leave node lock state matching user");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && cmd_ff == CMD_UPGRADE && ok_ff) |-> (desc == '0))
      else $error("upgrade success left a locked descendant");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_CHK) |-> (step_ff < n_act))
      else $error("ancestor walk ran past node count");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (sidx_ff <= n_act))
      else $error("descendant sweep index past node count");

endmodule

@@ verif/tb_hierarchical_lock_table_core.sv @@
// Testbench of hierarchical_lock_table_core: loads trees, then drives lock, unlock and upgrade
// items under several node counts and handshake patterns, and checks every success flag.
// Depends on hlt_pkg and the core; the outcome predictor lives in a small class below.
module tb_hierarchical_lock_table_core;
   import hlt_pkg::*;

   localparam int                HALF_PERIOD  = 5;
   localparam longint            RUN_LIMIT    = 400_000_000;
   localparam int                HOLD_CYCLES  = 500;
   localparam int                PHASE_ITEMS  = 150;
   localparam int                TAIL_CYCLES  = 300;
   localparam int                MAX_REPORTS  = 10;
   localparam logic [PAR_W-1:0]  NO_PARENT    = '1;
   localparam int                SEND_IDLE[4] = '{0, 59, 0, 15};
   localparam int                RECV_STALL[4] = '{0, 0, 59, 15};

   class lock_outcome_board;
      logic [USER_W-1:0] owner [NODES];
      logic [PAR_W-1:0]  parent [NODES];
      logic [CNT_W-1:0]  count_reg;
      bit                outcomes_due[$];
      int                mismatches;
      int                responses;
      int                granted_upgrades;
      int                per_cmd[4];

      function new();
         foreach (owner[i]) begin
            owner[i]  = '0;
            parent[i] = '0;
         end
         count_reg        = CNT_W'(NODES);
         mismatches       = 0;
         responses        = 0;
         granted_upgrades = 0;
         foreach (per_cmd[i]) per_cmd[i] = 0;
      endfunction

      function int in_use();
         if (count_reg == 0) return 1;
         if (count_reg > NODES) return NODES;
         return int'(count_reg);
      endfunction

      function int up_link(int idx, int n);
         logic [PAR_W-1:0] raw;
         raw = parent[idx];
         if (raw[PAR_W-1]) return -1;
         if (int'(raw) >= n) return -1;
         return int'(raw);
      endfunction

      function bit lies_below(int d, int anc, int n);
         int cur;
         int p;
         int s;
         if (d == 0 || d == anc) return 0;
         cur = d;
         for (s = 0; s < n; s++) begin
            p = up_link(cur, n);
            if (p < 0) return 0;
            if (p == anc) return 1;
            cur = p;
         end
         return 0;
      endfunction

      function bit try_upgrade(int nd, logic [USER_W-1:0] usr, int n);
         int cur;
         int p;
         int s;
         int d;
         bit found;
         cur   = nd;
         found = 0;
         for (s = 0; s < n; s++) begin
            if (owner[cur] != 0) return 0;
            p = up_link(cur, n);
            if (p < 0) break;
            cur = p;
         end
         for (d = 0; d < n; d++) begin
            if (owner[d] != 0 && lies_below(d, nd, n)) found = 1;
         end
         if (!found) return 0;
         for (d = 0; d < n; d++) begin
            if (owner[d] != 0 && lies_below(d, nd, n)) owner[d] = '0;
         end
         owner[nd] = usr;
         return 1;
      endfunction

      function void note_request(cmd_type cmd, int node, logic [USER_W-1:0] usr,
                                 logic [PAR_W-1:0] par);
         int n;
         bit ok;
         n  = in_use();
         ok = 0;
         per_cmd[int'(cmd)]++;
         if (cmd == CMD_LOAD) begin
            parent[node] = par;
            ok = 1;
         end else if (node < n) begin
            case (cmd)
               CMD_LOCK: begin
                  if (owner[node] == 0) begin
                     owner[node] = usr;
                     ok = 1;
                  end
               end
               CMD_UNLOCK: begin
                  if (owner[node] == usr) begin
                     owner[node] = '0;
                     ok = 1;
                  end
               end
               default: begin
                  ok = try_upgrade(node, usr, n);
                  if (ok) granted_upgrades++;
               end
            endcase
         end
         outcomes_due = {outcomes_due, ok};
      endfunction

      function void report(string what, int want, int got);
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s, expected %0d, actual %0d", $time, what, want, got);
      endfunction

      function void check_response(logic got);
         bit want;
         responses++;
         if (outcomes_due.size() == 0) begin
            report("response with no item waiting", -1, int'(got));
         end else begin
            want = outcomes_due.pop_front();
            if (got !== want) report("success flag", int'(want), int'(got));
         end
      endfunction

      function int pending();
         return outcomes_due.size();
      endfunction
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_wen    = 1'b0;
   logic [CNT_W-1:0]  csr_wdata  = CNT_W'(NODES);

   lock_outcome_board board = new();
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_tickets   = 0;
   int holds_served   = 0;
   int hold_left      = 0;
   int items_sent     = 0;

   hierarchical_lock_table_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata[0]);
         if (hold_left == 0 && holds_served != hold_tickets) begin
            holds_served = holds_served + 1;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_item(input cmd_type cmd, input int node, input logic [USER_W-1:0] usr,
                            input logic [PAR_W-1:0] par);
      logic [NODE_W-1:0] nd;
      nd = NODE_W'(node);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, par, usr, nd, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(cmd, node, usr, par);
      items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0 || !req_tready) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [CNT_W-1:0] value);
      drain();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      board.count_reg = value;
   endtask

   task automatic send_random(input int n);
      int                r;
      int                node;
      cmd_type           cmd;
      logic [USER_W-1:0] usr;
      logic [PAR_W-1:0]  par;
      r = $urandom_range(99);
      if (r < 10) cmd = CMD_LOAD;
      else if (r < 45) cmd = CMD_LOCK;
      else if (r < 70) cmd = CMD_UNLOCK;
      else cmd = CMD_UPGRADE;
      if ($urandom_range(99) < 85) node = $urandom_range(n - 1);
      else node = $urandom_range(NODES - 1);
      r = $urandom_range(99);
      if (r < 80) usr = USER_W'($urandom_range(1, 4));
      else if (r < 95) usr = USER_W'($urandom_range(1, 65535));
      else if (r < 98) usr = '0;
      else usr = '1;
      if (cmd == CMD_UNLOCK && board.owner[node] != 0 && $urandom_range(99) < 70)
         usr = board.owner[node];
      r = $urandom_range(99);
      if (r < 40) par = (node > 0) ? PAR_W'($urandom_range(node - 1)) : NO_PARENT;
      else if (r < 60) par = NO_PARENT;
      else par = PAR_W'($urandom_range(NODES - 1));
      send_item(cmd, node, usr, par);
   endtask

   initial begin
      #(RUN_LIMIT);
      $display("tb_hierarchical_lock_table_core NOT OK");
      $finish;
   end

   initial begin
      logic [CNT_W-1:0] phase_counts[8];
      int               ph;
      int               k;
      int               i;
      phase_counts = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd8, 7'd3, 7'd20, 7'd64};
      phase_counts[6] = CNT_W'($urandom_range(2, NODES - 1));
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_node_count(CNT_W'(NODES));
      for (i = 0; i < NODES; i++)
         send_item(CMD_LOAD, i, '0, (i == 0) ? NO_PARENT : PAR_W'((i - 1) / 2));

      send_item(CMD_LOCK,    5,  16'hFFFF, '0);
      send_item(CMD_LOCK,    5,  16'd1,    '0);
      send_item(CMD_UNLOCK,  5,  16'd1,    '0);
      send_item(CMD_UNLOCK,  5,  16'hFFFF, '0);
      send_item(CMD_LOCK,    63, 16'd1,    '0);
      send_item(CMD_UPGRADE, 1,  16'h1234, '0);
      send_item(CMD_UPGRADE, 0,  16'd2,    '0);
      send_item(CMD_UPGRADE, 3,  16'd2,    '0);
      send_item(CMD_UNLOCK,  0,  16'd2,    '0);
      send_item(CMD_UPGRADE, 2,  16'd3,    '0);
      send_item(CMD_LOCK,    0,  16'd0,    '0);
      send_item(CMD_UNLOCK,  7,  16'd0,    '0);
      send_item(CMD_LOCK,    10, 16'd3,    '0);
      send_item(CMD_UPGRADE, 4,  16'd0,    '0);
      send_item(CMD_LOCK,    10, 16'd4,    '0);
      send_item(CMD_LOAD,    63, '0,       PAR_W'(62));
      send_item(CMD_LOAD,    62, '0,       PAR_W'(63));
      send_item(CMD_LOAD,    61, '0,       PAR_W'(62));
      send_item(CMD_LOCK,    61, 16'd5,    '0);
      send_item(CMD_UPGRADE, 63, 16'd6,    '0);
      send_item(CMD_LOAD,    63, '0,       NO_PARENT);
      send_item(CMD_LOAD,    0,  '0,       PAR_W'(63));
      send_item(CMD_UPGRADE, 63, 16'd7,    '0);
      send_item(CMD_LOAD,    0,  '0,       NO_PARENT);

      for (ph = 0; ph < 8; ph++) begin
         write_node_count(phase_counts[ph]);
         send_idle_pct  = SEND_IDLE[ph % 4];
         recv_stall_pct = RECV_STALL[ph % 4];
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k == 50 && (ph == 0 || ph == 5)) hold_tickets = hold_tickets + 1;
            if (k == 90 && (ph == 1 || ph == 6)) drain();
            send_random(board.in_use());
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("%0d items over 8 node counts incl. 0, 1, 64 and 127; %0d responses checked",
               items_sent, board.responses);
      $display("loads %0d, locks %0d, unlocks %0d, upgrades %0d (%0d granted)",
               board.per_cmd[CMD_LOAD], board.per_cmd[CMD_LOCK], board.per_cmd[CMD_UNLOCK],
               board.per_cmd[CMD_UPGRADE], board.granted_upgrades);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("tb_hierarchical_lock_table_core OK");
      end else begin
         $display("tb_hierarchical_lock_table_core NOT OK");
      end
      $finish;
   end

endmodule
